// File: rtl/core/mwor_pkg.sv
// types, constants and helpers shared by the moving wall outlet reflection block
`timescale 1ns / 1ps
`default_nettype none
package mwor_pkg;

    localparam int SAT_W       = 56;
    localparam int MID_DEPTH   = 4;
    localparam int MID_PTR_W   = 2;
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_PTR_W   = 3;
    localparam int BACK_STAGES = 5;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_VELOCITY_AXIS      = 3'd0;
    localparam cfg_index_t CFG_GRADIENT_AXIS      = 3'd1;
    localparam cfg_index_t CFG_VELOCITY_GRADIENT  = 3'd2;
    localparam cfg_index_t CFG_REFERENCE_VELOCITY = 3'd3;
    localparam cfg_index_t CFG_BAND_WIDTH         = 3'd4;
    localparam cfg_index_t CFG_DOMAIN_WIDTH       = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0]        random_fraction;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               removed;
    } result_t;

    typedef struct packed {
        logic [1:0]         velocity_axis;
        logic [1:0]         gradient_axis;
        logic signed [31:0] velocity_gradient;
        logic signed [31:0] reference_velocity;
        logic [30:0]        band_width;
        logic [30:0]        domain_width;
    } cfg_t;

    typedef struct packed {
        logic               below;
        logic [32:0]        tsel;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic signed [15:0] nva;
        logic [15:0]        random_fraction;
    } mid_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[SAT_W-1:31]) || !(|v[SAT_W-1:31]))
        begin
            r = v[31:0];
        end
        else if (v[SAT_W-1])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/moving_wall_outlet_reflection.sv
// top level of the moving wall outlet reflection block
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   input    | push / full                | item   (mwor_pkg::in_item_t)
//   result   | pop / empty                | result (mwor_pkg::result_t)
//   config   | cfg_we, cfg_index          | cfg_data (32 bits)
//
// one beat per cycle sustained while results keep being popped
// path: front register, mid queue, five back stages, result queue
// rate is held by the 8-entry result queue credit over the five back stages
// reset clears all valid state, counts and config to defaults; no clearing pass
// pop low fills the result queue, the back stops issuing, the mid queue fills,
// then full rises
`timescale 1ns / 1ps
`default_nettype none
module moving_wall_outlet_reflection (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  mwor_pkg::in_item_t   item,
    output logic                 empty,
    input  logic                 pop,
    output mwor_pkg::result_t    result,
    input  logic                 cfg_we,
    input  mwor_pkg::cfg_index_t cfg_index,
    input  logic [31:0]          cfg_data
);
    import mwor_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    logic      mid_push;
    logic      mid_full;
    logic      mid_pop;
    logic      mid_empty;
    mid_item_t mid_wr;
    mid_item_t mid_rd;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VELOCITY_AXIS:      cfg_next.velocity_axis      = cfg_data[1:0];
                CFG_GRADIENT_AXIS:      cfg_next.gradient_axis      = cfg_data[1:0];
                CFG_VELOCITY_GRADIENT:  cfg_next.velocity_gradient  = cfg_data;
                CFG_REFERENCE_VELOCITY: cfg_next.reference_velocity = cfg_data;
                CFG_BAND_WIDTH:         cfg_next.band_width         = cfg_data[30:0];
                CFG_DOMAIN_WIDTH:       cfg_next.domain_width       = cfg_data[30:0];
                default:                cfg_next                    = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.velocity_axis      <= AXIS_X;
            cfg_reg.gradient_axis      <= AXIS_Y;
            cfg_reg.velocity_gradient  <= '0;
            cfg_reg.reference_velocity <= '0;
            cfg_reg.band_width         <= '0;
            cfg_reg.domain_width       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mwor_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cfg      (cfg_reg),
        .mid_push (mid_push),
        .mid_full (mid_full),
        .mid_item (mid_wr)
    );

    mwor_mid_fifo u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_wr),
        .full    (mid_full),
        .pop     (mid_pop),
        .empty   (mid_empty),
        .rd_data (mid_rd)
    );

    mwor_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_item  (mid_rd),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
`default_nettype wire

// File: rtl/core/mwor_front.sv
// front stage: accepts beats, picks the band region and wall multiplicand
`timescale 1ns / 1ps
`default_nettype none
module mwor_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mwor_pkg::in_item_t  item,
    input  mwor_pkg::cfg_t      cfg,
    output logic                mid_push,
    input  logic                mid_full,
    output mwor_pkg::mid_item_t mid_item
);
    import mwor_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    mid_item_t          slot_reg;
    mid_item_t          slot_next;
    logic [31:0]        count_reg;
    logic [31:0]        count_next;
    logic               advance;
    logic               accept;
    logic signed [31:0] p;
    logic signed [33:0] p2;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] t;
    logic               below;
    logic               above;

    assign advance  = !valid_reg || !mid_full;
    assign full     = !advance;
    assign accept   = push && advance;
    assign mid_push = valid_reg && !mid_full;
    assign mid_item = slot_reg;

    always_comb
    begin
        case (cfg.gradient_axis)
            AXIS_X:  p = item.pos_x;
            AXIS_Y:  p = item.pos_y;
            AXIS_Z:  p = item.pos_z;
            default: p = '0;
        endcase
        p2    = {p[31], p, 1'b0};
        lo    = $signed({3'b000, cfg.domain_width}) - $signed({3'b000, cfg.band_width});
        hi    = $signed({3'b000, cfg.domain_width}) + $signed({3'b000, cfg.band_width});
        t     = p2 - lo;
        below = p2 < lo;
        above = p2 > hi;

        slot_next.below = below;
        if (above)
        begin
            slot_next.tsel = {1'b0, cfg.band_width, 1'b0};
        end
        else if (below)
        begin
            slot_next.tsel = '0;
        end
        else
        begin
            slot_next.tsel = t[32:0];
        end
        slot_next.vel_x  = item.vel_x;
        slot_next.vel_y  = item.vel_y;
        slot_next.vel_z  = item.vel_z;
        slot_next.norm_x = item.norm_x;
        slot_next.norm_y = item.norm_y;
        slot_next.norm_z = item.norm_z;
        case (cfg.velocity_axis)
            AXIS_X:  slot_next.nva = item.norm_x;
            AXIS_Y:  slot_next.nva = item.norm_y;
            AXIS_Z:  slot_next.nva = item.norm_z;
            default: slot_next.nva = '0;
        endcase
        slot_next.random_fraction = item.random_fraction;

        valid_next = accept || (valid_reg && mid_full);
        count_next = accept ? count_reg + 32'd1 : count_reg;
    end

    // valid flag and collision count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg <= slot_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/mwor_mid_fifo.sv
// short queue of classified beats between front and back
`timescale 1ns / 1ps
`default_nettype none
module mwor_mid_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mwor_pkg::mid_item_t wr_data,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output mwor_pkg::mid_item_t rd_data
);
    import mwor_pkg::*;

    mid_item_t            mem_reg [MID_DEPTH];
    logic [MID_PTR_W-1:0] wr_ptr_reg;
    logic [MID_PTR_W-1:0] wr_ptr_next;
    logic [MID_PTR_W-1:0] rd_ptr_reg;
    logic [MID_PTR_W-1:0] rd_ptr_next;
    logic [MID_PTR_W:0]   count_reg;
    logic [MID_PTR_W:0]   count_next;

    assign full    = count_reg == (MID_PTR_W+1)'(MID_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (MID_PTR_W+1)'(push) - (MID_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/mwor_back.sv
// back pipeline: wall velocity, reflection, removal test and result queue
`timescale 1ns / 1ps
`default_nettype none
module mwor_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mwor_pkg::cfg_t      cfg,
    input  logic                mid_empty,
    output logic                mid_pop,
    input  mwor_pkg::mid_item_t mid_item,
    input  logic                pop,
    output logic                empty,
    output mwor_pkg::result_t   result
);
    import mwor_pkg::*;

    localparam int CNT_W = OUT_PTR_W + 1;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic signed [15:0] nva;
        logic [15:0]        rnd;
    } pass_t;

    logic [BACK_STAGES-1:0] valid_reg;
    logic [BACK_STAGES-1:0] valid_next;
    logic [CNT_W-1:0]       inflight;
    logic                   issue;
    pass_t                  in_pass;

    pass_t                  s1_pass;
    logic                   s1_below;
    logic signed [65:0]     s1_prod;
    logic signed [47:0]     s1_pvx;
    logic signed [47:0]     s1_pvy;
    logic signed [47:0]     s1_pvz;

    pass_t                  s2_pass;
    logic signed [49:0]     s2_dot;
    logic signed [31:0]     s2_wall;
    logic signed [31:0]     wall;

    pass_t                  s3_pass;
    logic signed [49:0]     s3_dot;
    logic signed [47:0]     s3_wn;

    pass_t                  s4_pass;
    logic signed [51:0]     k;
    logic signed [51:0]     ksum;
    logic signed [37:0]     s4_s;
    logic signed [51:0]     s4_k;
    logic [48:0]            s4_aup;
    logic                   s4_dz;
    logic signed [49:0]     neg_dot;

    pass_t                  s5_pass;
    logic signed [53:0]     s5_snx;
    logic signed [53:0]     s5_sny;
    logic signed [53:0]     s5_snz;
    logic [64:0]            s5_rp;
    logic [50:0]            s5_ak;
    logic [48:0]            s5_aup;
    logic                   s5_kneg;
    logic                   s5_dz;
    logic signed [51:0]     neg_k;

    result_t                fin;
    logic                   wr_en;

    result_t                mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   wr_ptr_next;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   rd_en;

    // credit: queued plus in-flight results never exceed the queue depth
    assign inflight = CNT_W'($countones(valid_reg));
    assign issue    = !mid_empty
                      && (({1'b0, count_reg} + {1'b0, inflight}) < (CNT_W+1)'(OUT_DEPTH));
    assign mid_pop  = issue;
    assign wr_en    = valid_reg[BACK_STAGES-1];
    assign empty    = count_reg == '0;
    assign rd_en    = pop && !empty;
    assign result   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_pass.vel_x  = mid_item.vel_x;
        in_pass.vel_y  = mid_item.vel_y;
        in_pass.vel_z  = mid_item.vel_z;
        in_pass.norm_x = mid_item.norm_x;
        in_pass.norm_y = mid_item.norm_y;
        in_pass.norm_z = mid_item.norm_z;
        in_pass.nva    = mid_item.nva;
        in_pass.rnd    = mid_item.random_fraction;
        valid_next     = {valid_reg[BACK_STAGES-2:0], issue};
    end

    // wall velocity
    always_comb
    begin
        if (s1_below)
        begin
            wall = cfg.reference_velocity;
        end
        else
        begin
            wall = sat32(SAT_W'($signed(s1_prod[65:17])) + SAT_W'(cfg.reference_velocity));
        end
    end

    // reflected normal speed and update scale
    always_comb
    begin
        k       = 52'(s3_dot) - (52'(s3_wn) <<< 1);
        ksum    = 52'(s3_dot) + k;
        neg_dot = -s3_dot;
    end

    always_comb
    begin
        neg_k = -s4_k;
    end

    always_comb
    begin
        fin.new_vel_x = sat32(SAT_W'(s5_pass.vel_x) - SAT_W'($signed(s5_snx[53:14])));
        fin.new_vel_y = sat32(SAT_W'(s5_pass.vel_y) - SAT_W'($signed(s5_sny[53:14])));
        fin.new_vel_z = sat32(SAT_W'(s5_pass.vel_z) - SAT_W'($signed(s5_snz[53:14])));
        fin.removed   = !s5_kneg || s5_dz
                        || ((51'(s5_aup) > s5_ak) && (67'(s5_rp) >= {s5_ak, 16'b0}));
    end

    always_ff @(posedge clk)
    begin
        s1_pass  <= in_pass;
        s1_below <= mid_item.below;
        s1_prod  <= $signed({1'b0, mid_item.tsel}) * cfg.velocity_gradient;
        s1_pvx   <= mid_item.vel_x * mid_item.norm_x;
        s1_pvy   <= mid_item.vel_y * mid_item.norm_y;
        s1_pvz   <= mid_item.vel_z * mid_item.norm_z;

        s2_pass  <= s1_pass;
        s2_dot   <= 50'(s1_pvx) + 50'(s1_pvy) + 50'(s1_pvz);
        s2_wall  <= wall;

        s3_pass  <= s2_pass;
        s3_dot   <= s2_dot;
        s3_wn    <= s2_wall * s2_pass.nva;

        s4_pass  <= s3_pass;
        s4_s     <= $signed(ksum[51:14]);
        s4_k     <= k;
        s4_aup   <= s3_dot[49] ? neg_dot[48:0] : s3_dot[48:0];
        s4_dz    <= s3_dot == '0;

        s5_pass  <= s4_pass;
        s5_snx   <= s4_s * s4_pass.norm_x;
        s5_sny   <= s4_s * s4_pass.norm_y;
        s5_snz   <= s4_s * s4_pass.norm_z;
        s5_rp    <= s4_pass.rnd * s4_aup;
        s5_ak    <= s4_k[51] ? neg_k[50:0] : s4_k[50:0];
        s5_aup   <= s4_aup;
        s5_kneg  <= s4_k[51];
        s5_dz    <= s4_dz;
    end

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= fin;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/mwor_checker.sv
// port-level checker for the moving wall outlet reflection block, with its bind
`timescale 1ns / 1ps
`default_nettype none
module mwor_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input mwor_pkg::in_item_t   item,
    input logic                 empty,
    input logic                 pop,
    input mwor_pkg::result_t    result,
    input logic                 cfg_we,
    input mwor_pkg::cfg_index_t cfg_index,
    input logic [31:0]          cfg_data
);
    import mwor_pkg::*;

    // once reset is seen, nothing is queued and beats can be taken
    assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("queues not clear in reset");

    // a waiting result holds until popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    // full only rises after a pushed beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (!full && !push) |=> !full)
        else $error("full rose with no beat pushed");

endmodule

bind moving_wall_outlet_reflection mwor_checker u_checker (.*);
`default_nettype wire

// File: verif/tb.sv
// testbench for the moving wall outlet reflection block: directed and random particles
`timescale 1ns / 1ps
module tb;
    import mwor_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 200;

    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam cfg_index_t CFG_SPARE_6 = 3'd6;
    localparam cfg_index_t CFG_SPARE_7 = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    in_item_t   item = '0;
    logic       empty;
    logic       pop = 1'b0;
    result_t    result;
    logic       cfg_we = 1'b0;
    cfg_index_t cfg_index = CFG_VELOCITY_AXIS;
    logic [31:0] cfg_data = '0;

    cfg_t        wall_cfg;
    result_t     reflected_q[$];
    int unsigned particle_count = 0;
    int          mismatch_count = 0;
    bit          feed_gaps = 1'b1;
    bit          drain_gaps = 1'b1;
    int          drain_hold = 0;
    int          y_edges[4] = '{10, 15, 20, 25};

    moving_wall_outlet_reflection dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic result_t reflect_particle(input in_item_t it);
        longint pos[3];
        longint vel[3];
        longint nrm[3];
        longint d, w, grad, refv, p2, wall, nva, dot, k, s, up;
        longint unsigned ak, aup, rnd;
        result_t r;
        pos = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
        vel = '{longint'(it.vel_x), longint'(it.vel_y), longint'(it.vel_z)};
        nrm = '{longint'(it.norm_x), longint'(it.norm_y), longint'(it.norm_z)};
        d = longint'(wall_cfg.domain_width);
        w = longint'(wall_cfg.band_width);
        grad = longint'(wall_cfg.velocity_gradient);
        refv = longint'(wall_cfg.reference_velocity);
        case (wall_cfg.gradient_axis)
            AXIS_X: p2 = 2 * pos[0];
            AXIS_Y: p2 = 2 * pos[1];
            AXIS_Z: p2 = 2 * pos[2];
            default: p2 = 0;
        endcase
        if (p2 < d - w)
        begin
            wall = refv;
        end
        else if (p2 > d + w)
        begin
            wall = ((w * grad) >>> 16) + refv;
        end
        else
        begin
            wall = (((p2 - d + w) * grad) >>> 17) + refv;
        end
        wall = longint'(clamp_q16(wall));
        case (wall_cfg.velocity_axis)
            AXIS_X: nva = nrm[0];
            AXIS_Y: nva = nrm[1];
            AXIS_Z: nva = nrm[2];
            default: nva = 0;
        endcase
        dot = vel[0] * nrm[0] + vel[1] * nrm[1] + vel[2] * nrm[2];
        k = dot - 2 * wall * nva;
        s = (dot + k) >>> 14;
        r.new_vel_x = clamp_q16(vel[0] - ((s * nrm[0]) >>> 14));
        r.new_vel_y = clamp_q16(vel[1] - ((s * nrm[1]) >>> 14));
        r.new_vel_z = clamp_q16(vel[2] - ((s * nrm[2]) >>> 14));
        up = -dot;
        if (k >= 0 || up == 0)
        begin
            r.removed = 1'b1;
        end
        else
        begin
            ak = -k;
            aup = (up < 0) ? -up : up;
            rnd = it.random_fraction;
            if (ak >= aup)
            begin
                r.removed = 1'b0;
            end
            else
            begin
                r.removed = (rnd * aup >= (ak << 16));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s differs, got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // one beat on the input side; leaves push high when no gap follows
    task automatic launch_particle(input in_item_t it);
        int gap;
        push <= 1'b1;
        item <= it;
        do
        begin
            @(posedge clk);
        end
        while (full !== 1'b0);
        reflected_q.push_back(reflect_particle(it));
        particle_count++;
        @(negedge clk);
        gap = feed_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (reflected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_VELOCITY_AXIS:      wall_cfg.velocity_axis = val[1:0];
            CFG_GRADIENT_AXIS:      wall_cfg.gradient_axis = val[1:0];
            CFG_VELOCITY_GRADIENT:  wall_cfg.velocity_gradient = val;
            CFG_REFERENCE_VELOCITY: wall_cfg.reference_velocity = val;
            CFG_BAND_WIDTH:         wall_cfg.band_width = val[30:0];
            CFG_DOMAIN_WIDTH:       wall_cfg.domain_width = val[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic in_item_t particle(input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] pz, input logic [31:0] vx,
                                          input logic [31:0] vy, input logic [31:0] vz,
                                          input logic [15:0] nx, input logic [15:0] ny,
                                          input logic [15:0] nz, input logic [15:0] rf);
        in_item_t it;
        it.pos_x = px;
        it.pos_y = py;
        it.pos_z = pz;
        it.vel_x = vx;
        it.vel_y = vy;
        it.vel_z = vz;
        it.norm_x = nx;
        it.norm_y = ny;
        it.norm_z = nz;
        it.random_fraction = rf;
        return it;
    endfunction

    function automatic logic [31:0] rand_pos();
        longint d, w, lo, span, p;
        d = longint'(wall_cfg.domain_width);
        w = longint'(wall_cfg.band_width);
        case ($urandom_range(0, 9))
            0: p = longint'(int'($urandom));
            1: p = (d - w) >>> 1;
            2: p = (d + w) >>> 1;
            3: p = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            default:
            begin
                lo = ((d - w) >>> 1) - (w >>> 2) - 262144;
                span = w + (w >>> 1) + 524288;
                p = lo + longint'($urandom_range(0, 32'(span)));
            end
        endcase
        return clamp_q16(p);
    endfunction

    function automatic logic [31:0] rand_speed();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return int'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic logic [15:0] rand_norm_comp();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic in_item_t rand_particle();
        in_item_t it;
        logic [15:0] n[3];
        int a, b, r;
        a = $urandom_range(0, 2);
        b = (a + $urandom_range(1, 2)) % 3;
        n = '{16'sd0, 16'sd0, 16'sd0};
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            n[a] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        end
        else if (r < 7)
        begin
            n[a] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
            n[b] = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
        end
        else
        begin
            n = '{rand_norm_comp(), rand_norm_comp(), rand_norm_comp()};
        end
        case ($urandom_range(0, 9))
            0: it.random_fraction = 16'h0000;
            1: it.random_fraction = 16'hffff;
            default: it.random_fraction = 16'($urandom_range(0, 65535));
        endcase
        it.pos_x = rand_pos();
        it.pos_y = rand_pos();
        it.pos_z = rand_pos();
        it.vel_x = rand_speed();
        it.vel_y = rand_speed();
        it.vel_z = rand_speed();
        it.norm_x = n[0];
        it.norm_y = n[1];
        it.norm_z = n[2];
        return it;
    endfunction

    function automatic logic [31:0] rand_width();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h0000_0000;
            1: v = 32'h7fff_ffff;
            2: v = $urandom;
            default: v = ($urandom_range(0, 64) << 16) | $urandom_range(0, 65535);
        endcase
        v[31] = 1'($urandom_range(0, 1));
        return v;
    endfunction

    function automatic logic [31:0] rand_signed_reg();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return int'($urandom_range(0, 1048576)) - 524288;
        endcase
    endfunction

    function automatic logic [1:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return AXIS_NONE;
            1, 2, 3: return AXIS_X;
            4, 5, 6: return AXIS_Y;
            default: return AXIS_Z;
        endcase
    endfunction

    task automatic random_config();
        write_reg(CFG_VELOCITY_AXIS, {30'd0, rand_axis()});
        write_reg(CFG_GRADIENT_AXIS, {30'd0, rand_axis()});
        write_reg(CFG_VELOCITY_GRADIENT, rand_signed_reg());
        write_reg(CFG_REFERENCE_VELOCITY, rand_signed_reg());
        write_reg(CFG_BAND_WIDTH, rand_width());
        write_reg(CFG_DOMAIN_WIDTH, rand_width());
    endtask

    task automatic test_reflection_extremes();
        launch_particle(particle(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h7fff_ffff, 32'h7fff_ffff, 16'sd16384, 0, 0, 16'h0000));
        launch_particle(particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000, -16'sd16384, 0, 0, 16'hffff));
        // zero normal gives zero incident speed
        launch_particle(particle(0, 0, 0, 32'h0001_0000, 32'hffff_0000, 32'h0003_0000,
                                 0, 0, 0, 16'h8000));
        launch_particle(particle(0, 32'h0002_0000, 0, 0, 32'hfffb_0000, 0,
                                 0, 16'sd16384, 0, 16'h1234));
        launch_particle(particle(0, 0, 0, 32'h0000_8000, 32'h0001_0000, 32'h0005_0000,
                                 0, 0, -16'sd16384, 16'h4000));
        // normal of more than unit length drives the result into saturation
        launch_particle(particle(0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 16'sd16384, 16'sd16384, 16'sd16384, 16'hffff));
        launch_particle(particle(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 -16'sd16384, -16'sd16384, -16'sd16384, 16'h0000));
        launch_particle(particle(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff,
                                 32'h8000_0000, 32'hffff_ffff, 16'sd11585, -16'sd11585,
                                 16'sd1, 16'h7fff));
    endtask

    task automatic test_wall_band();
        int y;
        settle();
        write_reg(CFG_VELOCITY_AXIS, {30'd0, AXIS_X});
        write_reg(CFG_GRADIENT_AXIS, {30'd0, AXIS_Y});
        write_reg(CFG_VELOCITY_GRADIENT, 32'h0001_0000);
        write_reg(CFG_REFERENCE_VELOCITY, 32'hfffd_0000);
        write_reg(CFG_BAND_WIDTH, 32'h000a_0000);
        write_reg(CFG_DOMAIN_WIDTH, 32'h001e_0000);
        launch_particle(particle(0, 0, 0, 32'hfff6_0000, 0, 0, 16'sd16384, 0, 0, 16'h0000));
        launch_particle(particle(0, 0, 0, 32'hfff6_0000, 0, 0, 16'sd16384, 0, 0, 16'hffff));
        foreach (y_edges[i])
        begin
            y = y_edges[i];
            launch_particle(particle(0, y << 16, 0, 32'hfff6_0000, 32'h0001_0000, 0,
                                     16'sd16384, 0, 0, 16'h9000));
        end
        // band wider than the domain
        settle();
        write_reg(CFG_BAND_WIDTH, 32'h0028_0000);
        write_reg(CFG_DOMAIN_WIDTH, 32'h000a_0000);
        launch_particle(particle(0, 32'hffec_0000, 0, 32'hfff6_0000, 0, 0,
                                 16'sd16384, 0, 0, 16'hc000));
        launch_particle(particle(0, 0, 0, 32'hfff6_0000, 0, 0, 16'sd16384, 0, 0, 16'hc000));
        launch_particle(particle(0, 32'h001e_0000, 0, 32'hfff6_0000, 0, 0,
                                 16'sd16384, 0, 0, 16'hc000));
        // axis selector three on both registers
        settle();
        write_reg(CFG_VELOCITY_AXIS, {30'd0, AXIS_NONE});
        write_reg(CFG_GRADIENT_AXIS, {30'd0, AXIS_NONE});
        launch_particle(particle(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'hfff6_0000,
                                 0, 0, 16'sd16384, 0, 0, 16'h2000));
        launch_particle(particle(0, 0, 0, 32'h0004_0000, 32'hfffc_0000, 0,
                                 16'sd11585, 16'sd11585, 0, 16'hf000));
    endtask

    task automatic test_spare_registers();
        settle();
        write_reg(CFG_SPARE_6, 32'hffff_ffff);
        write_reg(CFG_SPARE_7, 32'h5a5a_5a5a);
        launch_particle(particle(0, 32'h0010_0000, 0, 32'hfff6_0000, 0, 0,
                                 16'sd16384, 0, 0, 16'h8000));
    endtask

    task automatic test_wall_saturation();
        settle();
        write_reg(CFG_VELOCITY_AXIS, {30'd0, AXIS_Z});
        write_reg(CFG_GRADIENT_AXIS, {30'd0, AXIS_X});
        write_reg(CFG_VELOCITY_GRADIENT, 32'h7fff_ffff);
        write_reg(CFG_REFERENCE_VELOCITY, 32'h7fff_ffff);
        write_reg(CFG_BAND_WIDTH, 32'hffff_ffff);
        write_reg(CFG_DOMAIN_WIDTH, 32'h7fff_ffff);
        launch_particle(particle(32'h7fff_ffff, 0, 0, 0, 0, 32'h0001_0000,
                                 0, 0, 16'sd16384, 16'h0000));
        launch_particle(particle(32'h4000_0000, 0, 0, 0, 0, 32'hffff_0000,
                                 0, 0, -16'sd16384, 16'hffff));
        settle();
        write_reg(CFG_VELOCITY_GRADIENT, 32'h8000_0000);
        write_reg(CFG_REFERENCE_VELOCITY, 32'h8000_0000);
        launch_particle(particle(32'h7fff_ffff, 0, 0, 0, 0, 32'h0001_0000,
                                 0, 0, 16'sd16384, 16'h8000));
        launch_particle(particle(32'h8000_0000, 0, 0, 0, 0, 32'hffff_0000,
                                 0, 0, 16'sd16384, 16'h8000));
    endtask

    task automatic test_backpressure();
        settle();
        feed_gaps = 1'b0;
        drain_hold = HOLD_CYCLES;
        repeat (80) launch_particle(rand_particle());
        settle();
        feed_gaps = 1'b1;
    endtask

    task automatic test_random_streams();
        int phase;
        for (phase = 0; phase < 10; phase++)
        begin
            settle();
            random_config();
            feed_gaps = ($urandom_range(0, 3) != 0);
            drain_gaps = ($urandom_range(0, 3) != 0);
            repeat (120) launch_particle(rand_particle());
        end
        feed_gaps = 1'b1;
        drain_gaps = 1'b1;
    endtask

    // result side: random stalls plus a counted hold when asked
    initial
    begin : drain_results
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (drain_hold > 0)
            begin
                pop <= 1'b0;
                drain_hold--;
            end
            else if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop <= 1'b1;
                stall = drain_gaps ? pick_gap() : 0;
            end
        end
    end

    initial
    begin : check_results
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (reflected_q.size() == 0)
                begin
                    report_mismatch("beat with no particle pending", result.new_vel_x, '0);
                end
                else
                begin
                    want = reflected_q.pop_front();
                    if (result.new_vel_x !== want.new_vel_x)
                    begin
                        report_mismatch("new_vel_x", result.new_vel_x, want.new_vel_x);
                    end
                    if (result.new_vel_y !== want.new_vel_y)
                    begin
                        report_mismatch("new_vel_y", result.new_vel_y, want.new_vel_y);
                    end
                    if (result.new_vel_z !== want.new_vel_z)
                    begin
                        report_mismatch("new_vel_z", result.new_vel_z, want.new_vel_z);
                    end
                    if (result.removed !== want.removed)
                    begin
                        report_mismatch("removed", {31'd0, result.removed},
                                        {31'd0, want.removed});
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : run
        wall_cfg = '{velocity_axis: AXIS_X, gradient_axis: AXIS_Y, default: '0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reflection_extremes();
        test_wall_band();
        test_spare_registers();
        test_wall_saturation();
        test_backpressure();
        test_random_streams();
        settle();
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/mwor_pkg.sv
rtl/core/mwor_front.sv
rtl/core/mwor_mid_fifo.sv
rtl/core/mwor_back.sv
rtl/core/moving_wall_outlet_reflection.sv
rtl/core/mwor_checker.sv
verif/tb.sv
